// ----- sv/car_pkg.sv -----
// ----------------------------------------------------------------------------
// car_pkg
// Shared constants and types for the CAR page replacement directory.
// ----------------------------------------------------------------------------
package car_pkg;

  // Number of resident pages, and the depth of every list.
  localparam int CAPACITY = 16;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef logic [31:0] id_t;
  typedef logic [CW-1:0] cnt_t;

  // List selector for the shared shift loop.
  typedef enum logic [1:0] {
    L_T1 = 2'd0,
    L_T2 = 2'd1,
    L_B1 = 2'd2,
    L_B2 = 2'd3
  } list_t;

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_S1    = 18'h00002,
    ST_S2    = 18'h00004,
    ST_EV    = 18'h00008,
    ST_V1RD  = 18'h00010,
    ST_MV    = 18'h00020,
    ST_T2SEL = 18'h00040,
    ST_V2RD  = 18'h00080,
    ST_GPUSH = 18'h00100,
    ST_DROP  = 18'h00200,
    ST_TRIM  = 18'h00400,
    ST_G1    = 18'h00800,
    ST_G2    = 18'h01000,
    ST_APP   = 18'h02000,
    ST_DIVI  = 18'h04000,
    ST_DIV   = 18'h08000,
    ST_ADJ   = 18'h10000,
    ST_DONE  = 18'h20000
  } state_t;

endpackage

// ----- sv/car_page_replacement.sv -----
// ----------------------------------------------------------------------------
// car_page_replacement
// Page directory that answers hit or miss per page id with CAR replacement.
// ----------------------------------------------------------------------------
// Usage: one page id enters per transaction on the s_ channel; one result
// with the hit flag leaves per transaction on the m_ channel, in order.
// A small sequencer walks the four lists one entry per cycle with a single
// compare and a single shift step, so the time a request takes varies: a
// resident hit ends with its walk, and a miss may add an eviction, ghost moves
// and a target update. The list walks and the shift loop set that time.
// The step of the target comes from a bit-serial divider.
// s_tready is high only while the sequencer waits for a request. A finished
// result is held in the output register; a new request may be taken while
// it waits, but the next result is not loaded until the receiver takes the
// previous one, so a stalled receiver stalls the block after one request.
// Reset (rst, synchronous) empties all lists, clears reference bits and the
// target; id storage is not cleared, since only entries below a list's
// count are read.
// ----------------------------------------------------------------------------
module car_page_replacement import car_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] page_id
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] hit, [7:1] zero
);

  // List storage.
  id_t                t1_ids [CAPACITY];
  id_t                t2_ids [CAPACITY];
  id_t                b1_ids [CAPACITY];
  id_t                b2_ids [CAPACITY];
  logic [CAPACITY-1:0] t1_refs;
  logic [CAPACITY-1:0] t2_refs;
  cnt_t               t1_cnt, t2_cnt, b1_cnt, b2_cnt, target;

  // Sequencer registers.
  state_t state, ret;
  list_t  dsel, gsel;
  cnt_t   ctr, vpos, rem, quo, den, step;
  id_t    req_id, victim;
  logic   res_hit, dir_up;

  logic   out_hit;

  // Shared index and its successor for the shift loop.
  logic [IW-1:0] ix, ixn;
  cnt_t          ctr_inc;
  assign ctr_inc = ctr + cnt_t'(1);
  assign ix  = ctr[IW-1:0];
  assign ixn = ctr_inc[IW-1:0];

  // Count of the list the shift loop works on.
  cnt_t dcnt;
  always_comb begin
    unique case (dsel)
      L_T1:    dcnt = t1_cnt;
      L_T2:    dcnt = t2_cnt;
      L_B1:    dcnt = b1_cnt;
      default: dcnt = b2_cnt;
    endcase
  end

  // Last unreferenced T1 entry and first unreferenced T2 entry.
  logic          t1_found;
  logic [IW-1:0] t1_pos, t2_pos;
  always_comb begin
    t1_found = 1'b0;
    t1_pos   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cnt_t'(i) < t1_cnt && !t1_refs[i]) begin
        t1_found = 1'b1;
        t1_pos   = IW'(i);
      end
    end
    t2_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cnt_t'(i) < t2_cnt && !t2_refs[i]) t2_pos = IW'(i);
    end
  end

  // Shifted partial remainder for the trial subtraction of the bit-serial divider.
  logic [CW:0] trial;
  assign trial = {rem, quo[CW-1]};

  // Target sum before saturation.
  logic [CW:0] tsum;
  assign tsum = {1'b0, target} + {1'b0, step};

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {7'b0, out_hit};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
      out_hit  <= res_hit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Id storage, no reset.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_MV: begin
        if (ctr < t1_cnt) t2_ids[t2_cnt[IW-1:0]] <= t1_ids[ix];
      end
      ST_GPUSH: begin
        if (gsel == L_B1) begin
          if (b1_cnt < cnt_t'(CAPACITY)) b1_ids[b1_cnt[IW-1:0]] <= victim;
        end else begin
          if (b2_cnt < cnt_t'(CAPACITY)) b2_ids[b2_cnt[IW-1:0]] <= victim;
        end
      end
      ST_DROP: begin
        if (ctr_inc < dcnt) begin
          unique case (dsel)
            L_T1:    t1_ids[ix] <= t1_ids[ixn];
            L_T2:    t2_ids[ix] <= t2_ids[ixn];
            L_B1:    b1_ids[ix] <= b1_ids[ixn];
            default: b2_ids[ix] <= b2_ids[ixn];
          endcase
        end
      end
      ST_G1: begin
        if (ctr < b1_cnt && b1_ids[ix] == req_id && t2_cnt < cnt_t'(CAPACITY))
          t2_ids[t2_cnt[IW-1:0]] <= req_id;
      end
      ST_G2: begin
        if (ctr < b2_cnt && b2_ids[ix] == req_id && t2_cnt < cnt_t'(CAPACITY))
          t2_ids[t2_cnt[IW-1:0]] <= req_id;
      end
      ST_APP: begin
        if (t1_cnt < cnt_t'(CAPACITY)) t1_ids[t1_cnt[IW-1:0]] <= req_id;
      end
      default: ;
    endcase
  end

  // Sequencer, counts, reference bits and target.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ret     <= ST_IDLE;
      t1_refs <= '0;
      t2_refs <= '0;
      t1_cnt  <= '0;
      t2_cnt  <= '0;
      b1_cnt  <= '0;
      b2_cnt  <= '0;
      target  <= '0;
      ctr     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_id <= s_tdata;
            ctr    <= '0;
            state  <= ST_S1;
          end
        end
        // Walk T1 for a resident hit.
        ST_S1: begin
          if (ctr < t1_cnt) begin
            if (t1_ids[ix] == req_id) begin
              t1_refs[ix] <= 1'b1;
              res_hit     <= 1'b1;
              state       <= ST_DONE;
            end else begin
              ctr <= ctr_inc;
            end
          end else begin
            ctr   <= '0;
            state <= ST_S2;
          end
        end
        // Walk T2 for a resident hit.
        ST_S2: begin
          if (ctr < t2_cnt) begin
            if (t2_ids[ix] == req_id) begin
              t2_refs[ix] <= 1'b1;
              res_hit     <= 1'b1;
              state       <= ST_DONE;
            end else begin
              ctr <= ctr_inc;
            end
          end else begin
            res_hit <= 1'b0;
            ctr     <= '0;
            if ({1'b0, t1_cnt} + {1'b0, t2_cnt} >= (CW+1)'(CAPACITY)) state <= ST_EV;
            else state <= ST_TRIM;
          end
        end
        // Choose the eviction side.
        ST_EV: begin
          if (t1_cnt >= target) begin
            if (t1_found) begin
              ctr   <= cnt_t'(t1_pos);
              state <= ST_V1RD;
            end else begin
              ctr   <= '0;
              state <= ST_MV;
            end
          end else begin
            state <= ST_T2SEL;
          end
        end
        ST_V1RD: begin
          victim <= t1_ids[ix];
          vpos   <= ctr;
          gsel   <= L_B1;
          state  <= ST_GPUSH;
        end
        // Forced eviction: all of T1 moves to the tail of T2.
        ST_MV: begin
          if (ctr < t1_cnt) begin
            t2_refs[t2_cnt[IW-1:0]] <= 1'b0;
            t2_cnt <= t2_cnt + cnt_t'(1);
            ctr    <= ctr_inc;
          end else begin
            t1_cnt <= '0;
            state  <= ST_T2SEL;
          end
        end
        ST_T2SEL: begin
          if (t2_cnt != '0) begin
            ctr   <= cnt_t'(t2_pos);
            state <= ST_V2RD;
          end else begin
            state <= ST_TRIM;
          end
        end
        ST_V2RD: begin
          victim <= t2_ids[ix];
          vpos   <= ctr;
          gsel   <= L_B2;
          state  <= ST_GPUSH;
        end
        // Push the victim into its ghost list, dropping the oldest if full, then remove it from its resident list.
        ST_GPUSH: begin
          if ((gsel == L_B1 && b1_cnt >= cnt_t'(CAPACITY)) ||
              (gsel == L_B2 && b2_cnt >= cnt_t'(CAPACITY))) begin
            dsel  <= gsel;
            ctr   <= '0;
            ret   <= ST_GPUSH;
            state <= ST_DROP;
          end else begin
            if (gsel == L_B1) b1_cnt <= b1_cnt + cnt_t'(1);
            else b2_cnt <= b2_cnt + cnt_t'(1);
            dsel  <= (gsel == L_B1) ? L_T1 : L_T2;
            ctr   <= vpos;
            ret   <= ST_TRIM;
            state <= ST_DROP;
          end
        end
        // Shared shift loop: remove the entry at ctr from list dsel.
        ST_DROP: begin
          if (ctr_inc < dcnt) begin
            if (dsel == L_T1) t1_refs[ix] <= t1_refs[ixn];
            if (dsel == L_T2) t2_refs[ix] <= t2_refs[ixn];
            ctr <= ctr_inc;
          end else begin
            unique case (dsel)
              L_T1:    t1_cnt <= t1_cnt - cnt_t'(1);
              L_T2:    t2_cnt <= t2_cnt - cnt_t'(1);
              L_B1:    b1_cnt <= b1_cnt - cnt_t'(1);
              default: b2_cnt <= b2_cnt - cnt_t'(1);
            endcase
            ctr   <= '0;
            state <= ret;
          end
        end
        // Ghost trim.
        ST_TRIM: begin
          ctr <= '0;
          ret <= ST_G1;
          if ({1'b0, t1_cnt} + {1'b0, b1_cnt} >= (CW+1)'(CAPACITY) && b1_cnt != '0) begin
            dsel  <= L_B1;
            state <= ST_DROP;
          end else if ({1'b0, b1_cnt} + {1'b0, b2_cnt} >= (CW+1)'(CAPACITY) &&
                       b2_cnt != '0) begin
            dsel  <= L_B2;
            state <= ST_DROP;
          end else begin
            state <= ST_G1;
          end
        end
        // Walk B1 for a ghost hit.
        ST_G1: begin
          if (ctr < b1_cnt) begin
            if (b1_ids[ix] == req_id) begin
              if (t2_cnt < cnt_t'(CAPACITY)) begin
                t2_refs[t2_cnt[IW-1:0]] <= 1'b0;
                t2_cnt <= t2_cnt + cnt_t'(1);
              end
              dir_up <= 1'b1;
              dsel   <= L_B1;
              ret    <= ST_DIVI;
              state  <= ST_DROP;
            end else begin
              ctr <= ctr_inc;
            end
          end else begin
            ctr   <= '0;
            state <= ST_G2;
          end
        end
        // Walk B2 for a ghost hit.
        ST_G2: begin
          if (ctr < b2_cnt) begin
            if (b2_ids[ix] == req_id) begin
              if (t2_cnt < cnt_t'(CAPACITY)) begin
                t2_refs[t2_cnt[IW-1:0]] <= 1'b0;
                t2_cnt <= t2_cnt + cnt_t'(1);
              end
              dir_up <= 1'b0;
              dsel   <= L_B2;
              ret    <= ST_DIVI;
              state  <= ST_DROP;
            end else begin
              ctr <= ctr_inc;
            end
          end else begin
            state <= ST_APP;
          end
        end
        // Plain miss: append to T1.
        ST_APP: begin
          if (t1_cnt < cnt_t'(CAPACITY)) begin
            t1_refs[t1_cnt[IW-1:0]] <= 1'b0;
            t1_cnt <= t1_cnt + cnt_t'(1);
          end
          state <= ST_DONE;
        end
        // Set up the ratio of ghost sizes.
        ST_DIVI: begin
          if (b1_cnt == '0 || b2_cnt == '0) begin
            step  <= cnt_t'(1);
            state <= ST_ADJ;
          end else begin
            quo   <= dir_up ? b2_cnt : b1_cnt;
            den   <= dir_up ? b1_cnt : b2_cnt;
            rem   <= '0;
            ctr   <= cnt_t'(CW);
            state <= ST_DIV;
          end
        end
        // Restoring divider, one quotient bit per cycle.
        ST_DIV: begin
          if (trial >= {1'b0, den}) begin
            rem <= CW'(trial - {1'b0, den});
            quo <= {quo[CW-2:0], 1'b1};
          end else begin
            rem <= trial[CW-1:0];
            quo <= {quo[CW-2:0], 1'b0};
          end
          ctr <= ctr - cnt_t'(1);
          if (ctr == cnt_t'(1)) state <= ST_ADJ;
        end
        // Move the target, saturating at both ends.
        ST_ADJ: begin
          if (ret == ST_DIVI && ctr == '0 && quo == '0 && step != cnt_t'(1)) begin
            step <= cnt_t'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      // The divider result feeds the step when it finishes.
      if (state == ST_DIV && ctr == cnt_t'(1)) begin
        if (trial >= {1'b0, den}) step <= {quo[CW-2:0], 1'b1};
        else if (quo[CW-2:0] == '0) step <= cnt_t'(1);
        else step <= {quo[CW-2:0], 1'b0};
      end

      // Target update uses the settled step.
      if (state == ST_ADJ) begin
        if (dir_up) begin
          target <= (tsum > (CW+1)'(CAPACITY)) ? cnt_t'(CAPACITY) : tsum[CW-1:0];
        end else begin
          target <= (step >= target) ? '0 : target - step;
        end
      end
    end
  end

  // Resident lists never hold more than the capacity together, outside of
  // the forced move where T2 grows before T1 is emptied.
  a_resident_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_MV) |-> (({1'b0, t1_cnt} + {1'b0, t2_cnt}) <= (CW+1)'(CAPACITY)))
    else $error("resident lists exceed capacity");

  // Ghost lists stay within their depth.
  a_ghost_bound: assert property (@(posedge clk) disable iff (rst)
    b1_cnt <= cnt_t'(CAPACITY) && b2_cnt <= cnt_t'(CAPACITY))
    else $error("ghost list overflow");

  // The target never leaves its range.
  a_target_bound: assert property (@(posedge clk) disable iff (rst)
    target <= cnt_t'(CAPACITY))
    else $error("target out of range");

  // A result is loaded only from the final state.
  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid ##1 m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside of done state");

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// CAR page directory testbench
// Drives page requests through the stream ports, predicts the hit flag with
// an independent CAR directory model, and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import car_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the CAR lists and holds the hit flags still owed by the block.
  class car_scoreboard;
    id_t t1_ids[$];
    bit  t1_refs[$];
    id_t t2_ids[$];
    bit  t2_refs[$];
    id_t b1_ids[$];
    id_t b2_ids[$];
    int  target;
    bit  hit_queue[$];
    int  errors;
    int  hits;
    int  misses;

    function void push_t2(id_t id);
      if (t2_ids.size() < CAPACITY) begin
        t2_ids.push_back(id);
        t2_refs.push_back(1'b0);
      end
    endfunction

    function void push_ghost(ref id_t q[$], input id_t id);
      if (q.size() >= CAPACITY) q.pop_front();
      q.push_back(id);
    endfunction

    function int ratio(int num, int den);
      int q;
      if (num == 0 || den == 0) return 1;
      q = num / den;
      return (q < 1) ? 1 : q;
    endfunction

    // Frees one resident slot when the cache is full.
    function void evict_page();
      int pos;
      bit to_t2;
      to_t2 = 1'b1;
      if (t1_ids.size() >= target) begin
        pos = -1;
        foreach (t1_ids[i]) if (!t1_refs[i]) pos = i;
        if (pos >= 0) begin
          push_ghost(b1_ids, t1_ids[pos]);
          t1_ids.delete(pos);
          t1_refs.delete(pos);
          to_t2 = 1'b0;
        end else begin
          // Every recent page referenced: they all move to the frequent list.
          foreach (t1_ids[i]) push_t2(t1_ids[i]);
          t1_ids.delete();
          t1_refs.delete();
        end
      end
      if (to_t2 && t2_ids.size() > 0) begin
        pos = 0;
        foreach (t2_ids[i]) if (!t2_refs[i]) begin
          pos = i;
          break;
        end
        push_ghost(b2_ids, t2_ids[pos]);
        t2_ids.delete(pos);
        t2_refs.delete(pos);
      end
    endfunction

    // Applies one accepted request and records the expected hit flag.
    function void note_request(id_t id);
      int d;
      foreach (t1_ids[i]) if (t1_ids[i] == id) begin
        t1_refs[i] = 1'b1;
        hit_queue.push_back(1'b1);
        return;
      end
      foreach (t2_ids[i]) if (t2_ids[i] == id) begin
        t2_refs[i] = 1'b1;
        hit_queue.push_back(1'b1);
        return;
      end
      hit_queue.push_back(1'b0);
      if (t1_ids.size() + t2_ids.size() >= CAPACITY) evict_page();
      if (t1_ids.size() + b1_ids.size() >= CAPACITY && b1_ids.size() > 0)
        b1_ids.pop_front();
      else if (b1_ids.size() + b2_ids.size() >= CAPACITY && b2_ids.size() > 0)
        b2_ids.pop_front();
      foreach (b1_ids[i]) if (b1_ids[i] == id) begin
        push_t2(id);
        b1_ids.delete(i);
        d = ratio(b2_ids.size(), b1_ids.size());
        target = (target + d > CAPACITY) ? CAPACITY : target + d;
        return;
      end
      foreach (b2_ids[i]) if (b2_ids[i] == id) begin
        push_t2(id);
        b2_ids.delete(i);
        d = ratio(b1_ids.size(), b2_ids.size());
        target = (d >= target) ? 0 : target - d;
        return;
      end
      if (t1_ids.size() < CAPACITY) begin
        t1_ids.push_back(id);
        t1_refs.push_back(1'b0);
      end
    endfunction

    function void check_result(logic [7:0] data);
      bit exp_hit;
      if (hit_queue.size() == 0) begin
        $error("Result with no request pending: m_tdata=%h", data);
        errors++;
        return;
      end
      exp_hit = hit_queue.pop_front();
      if (exp_hit) hits++; else misses++;
      if (data[0] !== exp_hit) begin
        $error("Mismatch on hit: expected %0d, actual %0d", exp_hit, data[0]);
        errors++;
      end
      if (data[7:1] !== 7'd0) begin
        $error("Mismatch on pad: expected 0, actual %h", data[7:1]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  car_scoreboard sb;
  bit            idle_free;
  int            stall_cycles;
  int            sent;

  car_page_replacement dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: random backpressure, checks each accepted transaction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= idle_free ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (!rst) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
        $display("Watchdog expired with %0d results outstanding", sb.hit_queue.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Sends one request, with an optional random gap before it. Valid stays
  // high after acceptance until the next request or gap replaces it.
  task automatic send_page(id_t id);
    while (!idle_free && $urandom_range(99) < 31) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= id;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(id);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.hit_queue.size() != 0) @(posedge clk);
  endtask

  // Picks an id mostly from a small working set so hits and ghost hits occur.
  function automatic id_t pick_page(int span);
    int r;
    r = $urandom_range(99);
    if (r < 85) return 32'h1000 + $urandom_range(span - 1);
    if (r < 92) return ~(32'h1000 + $urandom_range(span - 1));
    return $urandom;
  endfunction

  initial begin
    int span;
    sb = new();
    idle_free    = 1'b0;
    sent         = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, repeat hits, then a full cache in which only three
    // ids are referenced, which forces evictions of unreferenced T1 entries.
    send_page(32'h0000_0000);
    send_page(32'hFFFF_FFFF);
    send_page(32'h0000_0000);
    send_page(32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) send_page(32'hA5A5_0000 + i);
    send_page(32'hA5A5_0003);
    send_page(32'h5A5A_0001);
    send_page(32'h5A5A_0002);
    send_page(32'h0000_0000);
    send_page(32'hA5A5_0000);

    // Sender holds off until the block has answered everything.
    wait_drained();

    // Random traffic; phases vary the working set so ghost hits push the
    // target both up and down. One phase runs with no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      span = (ph % 2 == 0) ? 24 : 40;
      idle_free = (ph == 2);
      for (int k = 0; k < 100; k++) send_page(pick_page(span));
    end
    idle_free = 1'b0;

    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d page requests: %0d hits and %0d misses, final target %0d.",
             sent, sb.hits, sb.misses, sb.target);
    if (sb.errors == 0 && sb.hit_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
